>>> design/arln_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// audio RMS level normalizer. No dependencies.
`default_nettype none

package arln_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int MAG_W              = SAMPLE_BITS + 1;
    localparam int SQ_W               = 2 * MAG_W;
    localparam int ACC_W              = 43;
    localparam int CNT_W              = 13;
    localparam int MAX_BUFFER_SAMPLES = 4096;
    localparam int HISTORY_DEPTH      = 8;
    localparam int HIST_PTR_W         = 3;
    localparam int RMS_W              = 16;
    localparam int TOTAL_W            = 19;
    localparam int PEAK_FRAC          = 21;
    localparam int PEAK_W             = 40;
    localparam int RATE_W             = 18;
    localparam int DTIME_W            = 12;
    localparam int DEN_W              = RATE_W + DTIME_W;
    localparam int CFG_DATA_W         = 18;
    localparam int CFG_INDEX_W        = 1;
    localparam int OUT_W              = 16;

    // shared divider: dividend left-aligned, one quotient bit per cycle
    localparam int DIV_W      = 56;
    localparam int DVS_W      = 40;
    localparam int DIV_STEP_W = 6;

    // integer root: 34-bit radicand, two bits per cycle
    localparam int SQRT_IN_W   = 34;
    localparam int SQRT_ROOT_W = 17;
    localparam int SQRT_REM_W  = 19;
    localparam int SQRT_CNT_W  = 5;
    localparam int SQRT_STEPS  = SQRT_IN_W / 2;

    localparam logic [DIV_STEP_W-1:0] STEPS_RMS = DIV_STEP_W'(ACC_W);
    localparam logic [DIV_STEP_W-1:0] STEPS_DEC = DIV_STEP_W'(CNT_W + 40);
    localparam logic [DIV_STEP_W-1:0] STEPS_Q   = DIV_STEP_W'(DIV_W);

    // peak floor: 0.001 of full scale in peak units
    localparam logic [PEAK_W-1:0] PEAK_THR = PEAK_W'(66 * HISTORY_DEPTH) << PEAK_FRAC;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_TIME  = 1'b1;

    typedef enum logic [1:0] {
        DIV_RMS,
        DIV_DEC,
        DIV_Q
    } div_sel_t;

    typedef struct packed {
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     hist_upd;
        logic     peak_set;
        logic     peak_dec;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic level_gt_peak;
        logic peak_gt_thr;
        logic peak_zero;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> design/audio_rms_level_normalizer_unit.sv
// Top level of the audio RMS level normalizer: stream ports, config port,
// controller and datapath. Depends on arln_pkg, arln_ctrl, arln_datapath.
//
//   channel   direction  handshake              payload
//   s_axis    in         s_axis_tvalid/tready   tdata[15:0] sample, tlast last_sample
//   m_axis    out        m_axis_tvalid/tready   tdata[15:0] intensity
//   cfg       in         cfg_valid/cfg_ready    cfg_index (0 rate, 1 decay), cfg_data
//
// A sample without tlast is accumulated as it is taken; words stream back to back.
// A tlast word starts the buffer-end sequence (divide, root, history, peak,
// normalize) on one shared bit-serial divider. s_axis_tready is low until
// the result is registered. A result waiting on m_axis does not block
// samples; a second buffer end waits for it. Reset clears the control,
// accumulator, history and peak state; cfg_ready is always high.
`default_nettype none

module audio_rms_level_normalizer_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [15:0]                         s_axis_tdata,  // [15:0] sample
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [15:0]                         m_axis_tdata,  // [15:0] intensity
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [arln_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [arln_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import arln_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;
    logic      in_accept;

    assign s_axis_tready = in_ready;
    assign in_accept     = s_axis_tvalid && in_ready;
    assign cfg_ready     = 1'b1;

    arln_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_last   (s_axis_tlast),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready)
    );

    arln_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_sample (signed'(s_axis_tdata[SAMPLE_BITS-1:0])),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> design/arln_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on arln_pkg.
`default_nettype none

module arln_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [arln_pkg::DIV_W-1:0]       dividend,
    input  wire logic [arln_pkg::DVS_W-1:0]       divisor,
    input  wire logic [arln_pkg::DIV_STEP_W-1:0]  steps,
    output logic      [arln_pkg::DIV_W-1:0]       quotient,
    output logic                                  done
);
    import arln_pkg::*;

    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [DVS_W-1:0]      rem_reg, rem_next;
    logic [DVS_W-1:0]      dvs_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DVS_W:0]        rem_sh;
    logic [DVS_W:0]        diff;
    logic                  ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == DIV_STEP_W'(1) |=> done_reg && !busy_reg)
        else $error("divider missed its done pulse");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

>>> design/arln_ctrl.sv
// Buffer-end sequencer: steps the datapath through divide, root, history,
// peak update and normalization. Depends on arln_pkg.
`default_nettype none

module arln_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_accept,
    input  wire logic                 in_last,
    input  wire arln_pkg::dp_stat_t   stat,
    output arln_pkg::ctrl_cmd_t       cmd,
    output logic                      in_ready
);
    import arln_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RMS_DIV,
        S_RMS_WAIT,
        S_SQRT,
        S_SQRT_WAIT,
        S_HIST,
        S_PEAK_CHK,
        S_PEAK_SET,
        S_DEC_DIV,
        S_DEC_WAIT,
        S_DEC_APPLY,
        S_Q_CHK,
        S_Q_DIV,
        S_Q_WAIT,
        S_OUT_WAIT,
        S_OUT_LOAD
    } state_t;

    state_t    state_reg, state_next;
    ctrl_cmd_t cmd_reg, cmd_next;
    logic      in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_accept && in_last) state_next = S_RMS_DIV;
            S_RMS_DIV:   state_next = S_RMS_WAIT;
            S_RMS_WAIT:  if (stat.div_done) state_next = S_SQRT;
            S_SQRT:      state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (stat.sqrt_done) state_next = S_HIST;
            S_HIST:      state_next = S_PEAK_CHK;
            S_PEAK_CHK:
            begin
                if (stat.level_gt_peak)
                    state_next = S_PEAK_SET;
                else if (stat.peak_gt_thr)
                    state_next = S_DEC_DIV;
                else
                    state_next = S_Q_CHK;
            end
            S_PEAK_SET:  state_next = S_Q_CHK;
            S_DEC_DIV:   state_next = S_DEC_WAIT;
            S_DEC_WAIT:  if (stat.div_done) state_next = S_DEC_APPLY;
            S_DEC_APPLY: state_next = S_Q_CHK;
            S_Q_CHK:     state_next = stat.peak_zero ? S_OUT_WAIT : S_Q_DIV;
            S_Q_DIV:     state_next = S_Q_WAIT;
            S_Q_WAIT:    if (stat.div_done) state_next = S_OUT_WAIT;
            S_OUT_WAIT:  if (stat.out_free) state_next = S_OUT_LOAD;
            S_OUT_LOAD:  state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase

        // commands are decoded from the next state and registered, so each
        // one is active during the cycle its state is held
        cmd_next            = '0;
        cmd_next.div_sel    = DIV_RMS;
        cmd_next.div_start  = state_next inside {S_RMS_DIV, S_DEC_DIV, S_Q_DIV};
        if (state_next == S_DEC_DIV)
            cmd_next.div_sel = DIV_DEC;
        else if (state_next == S_Q_DIV)
            cmd_next.div_sel = DIV_Q;
        cmd_next.sqrt_start = state_next == S_SQRT;
        cmd_next.hist_upd   = state_next == S_HIST;
        cmd_next.peak_set   = state_next == S_PEAK_SET;
        cmd_next.peak_dec   = state_next == S_DEC_APPLY;
        cmd_next.out_load   = state_next == S_OUT_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            in_ready_reg <= state_next == S_IDLE;
        end
    end

    assign cmd      = cmd_reg;
    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

>>> design/arln_datapath.sv
// Datapath: square accumulator, config registers, integer root, RMS history
// ring, peak tracker and output register. Depends on arln_pkg, arln_div.
`default_nettype none

module arln_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_accept,
    input  wire logic signed [arln_pkg::SAMPLE_BITS-1:0] in_sample,
    input  wire logic                               cfg_we,
    input  wire logic [arln_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [arln_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire arln_pkg::ctrl_cmd_t                cmd,
    output arln_pkg::dp_stat_t                      stat,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic      [arln_pkg::OUT_W-1:0]         out_data
);
    import arln_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [DTIME_W-1:0] dtime_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [RATE_W-1:0]  rate_eff;
    logic [DTIME_W-1:0] dtime_eff;

    logic [ACC_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   mag;
    logic [SQ_W-1:0]    sq;

    logic [RMS_W-1:0]      hist_reg [HISTORY_DEPTH];
    logic [HIST_PTR_W-1:0] ptr_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [PEAK_W-1:0]     peak_reg;
    logic [PEAK_W-1:0]     level;
    logic [RMS_W-1:0]      rms;

    logic [OUT_W-1:0]   out_data_reg;
    logic               out_valid_reg;

    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic [DIV_STEP_W-1:0] div_steps;
    logic [DIV_W-1:0]      div_q;
    logic                  div_done;

    logic [SQRT_IN_W-1:0]   sq_val_reg;
    logic [SQRT_REM_W-1:0]  sq_rem_reg;
    logic [SQRT_ROOT_W-1:0] sq_root_reg;
    logic [SQRT_CNT_W-1:0]  sq_cnt_reg;
    logic                   sq_busy_reg;
    logic                   sq_done_reg;
    logic [SQRT_REM_W+1:0]  sq_rem_sh;
    logic [SQRT_REM_W+1:0]  sq_trial;
    logic                   sq_ge;
    logic [SQRT_REM_W+1:0]  sq_diff;

    // ---- per-sample accumulate ----
    always_comb
    begin
        mag = in_sample[SAMPLE_BITS-1]
            ? MAG_W'(1 << SAMPLE_BITS) - {1'b0, in_sample}
            : {1'b0, in_sample};
        sq  = mag * mag;
    end

    always_comb
    begin
        rate_eff  = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
        dtime_eff = (dtime_reg == '0) ? DTIME_W'(1) : dtime_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_W'(48000);
            dtime_reg <= DTIME_W'(330);
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_DECAY_TIME:  dtime_reg <= cfg_data[DTIME_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.out_load)
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            else if (in_accept && cnt_reg < CNT_W'(MAX_BUFFER_SAMPLES))
            begin
                acc_reg <= acc_reg + ACC_W'(sq);
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= DEN_W'(rate_eff) * DEN_W'(dtime_eff);
    end

    // ---- shared divider operands ----
    always_comb
    begin
        case (cmd.div_sel)
            DIV_RMS:
            begin
                div_dividend = {acc_reg, (DIV_W - ACC_W)'(0)};
                div_divisor  = DVS_W'(cnt_reg);
                div_steps    = STEPS_RMS;
            end
            DIV_DEC:
            begin
                // count * 2^40, left-aligned
                div_dividend = {cnt_reg, (DIV_W - CNT_W)'(0)};
                div_divisor  = DVS_W'(den_reg);
                div_steps    = STEPS_DEC;
            end
            DIV_Q:
            begin
                // level * 65535 = total * (2^16 - 1) * 2^21
                div_dividend = {total_reg, (DIV_W - TOTAL_W)'(0)}
                             - {(DIV_W - TOTAL_W - PEAK_FRAC)'(0), total_reg,
                                PEAK_FRAC'(0)};
                div_divisor  = peak_reg;
                div_steps    = STEPS_Q;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
                div_steps    = STEPS_Q;
            end
        endcase
    end

    arln_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_q),
        .done     (div_done)
    );

    // ---- integer root, two radicand bits per cycle ----
    always_comb
    begin
        sq_rem_sh = {sq_rem_reg, sq_val_reg[SQRT_IN_W-1 -: 2]};
        sq_trial  = (SQRT_REM_W + 2)'({sq_root_reg, 2'b01});
        sq_ge     = sq_rem_sh >= sq_trial;
        sq_diff   = sq_rem_sh - sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= SQRT_CNT_W'(SQRT_STEPS);
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == SQRT_CNT_W'(1))
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            // mean square scaled to Q0.32; an empty buffer gives zero
            sq_val_reg  <= (cnt_reg == '0) ? '0 : {div_q[SQRT_IN_W-3:0], 2'b00};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_val_reg  <= {sq_val_reg[SQRT_IN_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? sq_diff[SQRT_REM_W-1:0] : sq_rem_sh[SQRT_REM_W-1:0];
            sq_root_reg <= {sq_root_reg[SQRT_ROOT_W-2:0], sq_ge};
        end
    end

    assign rms   = sq_root_reg[SQRT_ROOT_W-1] ? '1 : sq_root_reg[RMS_W-1:0];
    assign level = {total_reg, PEAK_FRAC'(0)};

    // ---- history ring and peak ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
            ptr_reg   <= '0;
            total_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            if (cmd.hist_upd)
            begin
                total_reg         <= total_reg + TOTAL_W'(rms) - TOTAL_W'(hist_reg[ptr_reg]);
                hist_reg[ptr_reg] <= rms;
                ptr_reg           <= ptr_reg + 1'b1;
            end
            if (cmd.peak_set)
                peak_reg <= level;
            else if (cmd.peak_dec)
                peak_reg <= (div_q >= DIV_W'(peak_reg)) ? '0 : peak_reg - div_q[PEAK_W-1:0];
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (peak_reg == '0)
                out_data_reg <= '0;
            else if (|div_q[DIV_W-1:OUT_W])
                out_data_reg <= '1;
            else
                out_data_reg <= div_q[OUT_W-1:0];
        end
    end

    always_comb
    begin
        stat.div_done      = div_done;
        stat.sqrt_done     = sq_done_reg;
        stat.level_gt_peak = level > peak_reg;
        stat.peak_gt_thr   = peak_reg > PEAK_THR;
        stat.peak_zero     = peak_reg == '0;
        stat.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result loaded over an untaken word");

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start || cmd.hist_upd |-> !sq_busy_reg)
        else $error("root unit used while busy");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BUFFER_SAMPLES))
        else $error("sample count past buffer limit");

endmodule

`default_nettype wire

>>> sim/audio_rms_level_normalizer_unit_tb.sv
// Self-checking bench for audio_rms_level_normalizer_unit: streams sample buffers,
// predicts each buffer-end intensity in SV and checks every m_axis word.
// Depends on arln_pkg and the design sources only.

module audio_rms_level_normalizer_unit_tb;
    import arln_pkg::*;

    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 250;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_WORDS   = 305;
    localparam int STALL_AT_WORD = 400;
    localparam int STALL_CYCLES  = 3000;

    // peak decrement numerator per sample: 65536 * HISTORY_DEPTH in peak units
    localparam logic [63:0] DECAY_UNIT = 64'(HISTORY_DEPTH) << (16 + PEAK_FRAC);

    localparam logic [CFG_DATA_W-1:0] RATE_SET [NUM_PHASES] =
        '{18'd48000, 18'd0, 18'd8000, 18'd192000, 18'h3FFFF, 18'd1};
    // upper bits set in one decay write: only the low 12 bits count
    localparam logic [CFG_DATA_W-1:0] DECAY_SET [NUM_PHASES] =
        '{18'd330, 18'd0, 18'h3F001, 18'd3600, 18'd4095, 18'd1};

    // {sample, last}
    localparam logic [16:0] DIRECTED_WORDS [16] = '{
        {16'h0000, 1'b1},
        {16'h7FFF, 1'b1},
        {16'h8000, 1'b0}, {16'h8000, 1'b1},
        {16'hFFFF, 1'b0}, {16'h0001, 1'b0}, {16'h5555, 1'b0}, {16'hAAAA, 1'b1},
        {16'h0001, 1'b1},
        {16'h0000, 1'b1},
        {16'h0000, 1'b1},
        {16'h8000, 1'b0}, {16'h7FFF, 1'b0}, {16'h8000, 1'b1},
        {16'h0000, 1'b1},
        {16'h0001, 1'b1}
    };

    typedef struct packed {
        logic [15:0] smp;
        logic        last;
    } sample_word_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata  = '0;    // [15:0] sample
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;          // [15:0] intensity
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    sample_word_t sample_queue [$];
    logic [15:0]  intensity_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int words_in      = 0;
    int stall_left    = 0;
    int cycles        = 0;
    bit long_stall_done = 1'b0;

    // predictor state
    logic [42:0]  sq_sum     = '0;
    logic [12:0]  smp_cnt    = '0;
    logic [15:0]  rms_ring [HISTORY_DEPTH];
    logic [2:0]   ring_ptr   = '0;
    logic [18:0]  ring_total = '0;
    logic [39:0]  peak       = '0;
    logic [17:0]  rate_reg   = 18'd48000;
    logic [11:0]  decay_reg  = 12'd330;

    audio_rms_level_normalizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Accumulate one sample; on a buffer end produce the normalized level.
    function automatic bit level_step(input logic [15:0] smp, input logic last,
                                      output logic [15:0] intensity);
        logic [16:0] mag;
        logic [63:0] mean_sq;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] level;
        logic [63:0] den;
        logic [63:0] dec;
        logic [63:0] q;
        intensity = '0;
        if (smp_cnt < MAX_BUFFER_SAMPLES)
        begin
            mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
            sq_sum = sq_sum + 43'(mag) * 43'(mag);
            smp_cnt = smp_cnt + 13'd1;
        end
        if (!last)
            return 1'b0;

        root = '0;
        if (smp_cnt != 0)
        begin
            mean_sq = (64'(sq_sum) / 64'(smp_cnt)) << 2;   // to Q0.32
            for (int b = 17; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= mean_sq)
                    root = trial;
            end
            if (root > 64'd65535)
                root = 64'd65535;
        end
        ring_total = 19'(64'(ring_total) + root - 64'(rms_ring[ring_ptr]));
        rms_ring[ring_ptr] = root[15:0];
        ring_ptr = ring_ptr + 3'd1;

        level = 64'(ring_total) << PEAK_FRAC;
        if (level > 64'(peak))
            peak = level[39:0];
        else if (peak > PEAK_THR)
        begin
            den = 64'(rate_reg == 0 ? 18'd1 : rate_reg)
                * 64'(decay_reg == 0 ? 12'd1 : decay_reg);
            dec = 64'(smp_cnt) * DECAY_UNIT / den;
            peak = (dec >= 64'(peak)) ? '0 : peak - dec[39:0];
        end

        if (peak == 0)
            q = '0;
        else
        begin
            q = level * 64'd65535 / 64'(peak);
            if (q > 64'd65535)
                q = 64'd65535;
        end
        intensity = q[15:0];
        sq_sum = '0;
        smp_cnt = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycles, what);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
            rate_reg = val;
        else
            decay_reg = val[11:0];
    endtask

    // Buffers of random length and loudness, always closed by a last word.
    task automatic queue_buffers(input int n_words);
        int          queued;
        int          len;
        int          kind;
        int          sh;
        logic [15:0] smp;
        queued = 0;
        while (queued < n_words)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
            kind = $urandom_range(3);
            sh   = $urandom_range(14);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0: smp = 16'($urandom);
                    1:
                    begin
                        smp = 16'($urandom_range((1 << sh) - 1));
                        if ($urandom_range(1))
                            smp = -smp;
                    end
                    2: smp = ($urandom_range(7) == 0) ? 16'($urandom_range(3)) : 16'h0000;
                    default: smp = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(15))
                                                     : 16'h7FFF - 16'($urandom_range(15));
                endcase
                sample_queue.push_back('{smp: smp, last: (i == len - 1)});
            end
            queued += len;
        end
    endtask

    task automatic settle();
        while (sample_queue.size() != 0 || s_axis_tvalid || intensity_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sample_queue[0].smp;
                s_axis_tlast  <= sample_queue[0].last;
                void'(sample_queue.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // accepted samples feed the predictor
    always @(posedge clk)
    begin : sample_side
        logic [15:0] want;
        bit          produced;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            words_in <= words_in + 1;
            produced = level_step(s_axis_tdata, s_axis_tlast, want);
            if (produced)
                intensity_due.push_back(want);
        end
    end

    // result sink, with one long hold-off so the input backs up
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (!long_stall_done && words_in >= STALL_AT_WORD)
        begin
            long_stall_done <= 1'b1;
            stall_left      <= STALL_CYCLES;
            m_axis_tready   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (intensity_due.size() == 0)
                flag_mismatch($sformatf("intensity %0d with no buffer end pending",
                                        m_axis_tdata));
            else
            begin
                if (m_axis_tdata !== intensity_due[0])
                    flag_mismatch($sformatf("intensity got %0d want %0d",
                                            m_axis_tdata, intensity_due[0]));
                void'(intensity_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
            rms_ring[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, saturating root, zero peak, decay at reset config
        send_idle_pct = 29;
        recv_idle_pct = 78;
        for (int i = 0; i < 16; i++)
            sample_queue.push_back(DIRECTED_WORDS[i]);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_SAMPLE_RATE, RATE_SET[ph]);
            write_reg(CFG_DECAY_TIME, DECAY_SET[ph]);
            if (ph < 2)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 78;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_buffers(PHASE_WORDS);
            settle();
        end

        if (mismatches == 0 && intensity_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
